// File: src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a condition in the next one.
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// File: src/icv_pkg.sv
`timescale 1ns / 1ps

package icv_pkg;

  localparam int CHAR_W     = 8;
  localparam int CNT_W      = 6;
  localparam int REM_W      = 7;
  localparam int PREFIX_LEN = 4;

  localparam logic [CNT_W-1:0] CNT_MAX    = 6'd63;
  localparam logic [CNT_W-1:0] NAT_HEAD   = 6'd13;
  localparam logic [CNT_W-1:0] NAT_LEN    = 6'd15;
  localparam logic [REM_W-1:0] SI_BASE    = 7'd98;
  localparam logic [11:0]      MOD_BASE   = 12'd97;
  // 100 mod 97, folds a two-digit letter value in one step
  localparam logic [11:0]      LETTER_MUL = 12'd3;
  // 10^6 mod 97, shifts the remainder past a six-digit prefix
  localparam logic [11:0]      PREFIX_MUL = 12'd27;
  // floor(2^16 / 97), reciprocal for the remainder
  localparam logic [21:0]      MOD_RECIP  = 22'd675;

  localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z     = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LO_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z     = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;
  localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_S        = 8'h53;
  localparam logic [CHAR_W-1:0] CH_I        = 8'h49;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_upper(input logic [CHAR_W-1:0] c);
    return (c >= CH_UP_A) && (c <= CH_UP_Z);
  endfunction

  function automatic logic is_lower(input logic [CHAR_W-1:0] c);
    return (c >= CH_LO_A) && (c <= CH_LO_Z);
  endfunction

  // x mod 97 for x below 4096: reciprocal estimate, one correction step
  function automatic logic [REM_W-1:0] mod97(input logic [11:0] x);
    logic [21:0] prod;
    logic [5:0]  q;
    logic [11:0] r;
    prod = 22'(x) * MOD_RECIP;
    q    = prod[21:16];
    r    = x - 12'(q) * MOD_BASE;
    if (r >= MOD_BASE) begin
      r = r - MOD_BASE;
    end
    return r[REM_W-1:0];
  endfunction

  // fold one uppercase letter (two digits) or one digit into a remainder
  function automatic logic [REM_W-1:0] fold_char(input logic [REM_W-1:0] rem,
                                                 input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    logic [REM_W-1:0]  res;
    v   = c - CH_UP_A + LETTER_BASE;
    res = rem;
    if (is_upper(c)) begin
      res = mod97(12'(rem) * LETTER_MUL + 12'(v));
    end else if (is_digit(c)) begin
      res = mod97(12'(rem) * 12'd10 + 12'(c[3:0]));
    end
    return res;
  endfunction

  // national IBAN length by country code, 0 when unknown
  function automatic logic [CNT_W-1:0] rom_length(input logic [CHAR_W-1:0] a,
                                                  input logic [CHAR_W-1:0] b);
    logic [CNT_W-1:0] len;
    unique case ({a, b})
      "AD": len = 6'd24; "AE": len = 6'd23; "AL": len = 6'd28; "AT": len = 6'd20;
      "AZ": len = 6'd28; "BA": len = 6'd20; "BE": len = 6'd16; "BG": len = 6'd22;
      "BH": len = 6'd22; "BI": len = 6'd27; "BR": len = 6'd29; "BY": len = 6'd28;
      "CH": len = 6'd21; "CR": len = 6'd22; "CY": len = 6'd28; "CZ": len = 6'd24;
      "DE": len = 6'd22; "DJ": len = 6'd27; "DK": len = 6'd18; "DO": len = 6'd28;
      "EE": len = 6'd20; "EG": len = 6'd29; "ES": len = 6'd24; "FI": len = 6'd18;
      "FO": len = 6'd18; "FR": len = 6'd27; "GB": len = 6'd22; "GE": len = 6'd22;
      "GI": len = 6'd23; "GL": len = 6'd18; "GR": len = 6'd27; "GT": len = 6'd28;
      "HR": len = 6'd21; "HU": len = 6'd28; "IE": len = 6'd22; "IL": len = 6'd23;
      "IQ": len = 6'd23; "IS": len = 6'd26; "IT": len = 6'd27; "JO": len = 6'd30;
      "KM": len = 6'd27; "KW": len = 6'd30; "KZ": len = 6'd20; "LB": len = 6'd28;
      "LC": len = 6'd32; "LI": len = 6'd21; "LT": len = 6'd20; "LU": len = 6'd20;
      "LV": len = 6'd21; "LY": len = 6'd25; "MC": len = 6'd27; "MD": len = 6'd24;
      "ME": len = 6'd22; "MK": len = 6'd19; "MR": len = 6'd27; "MT": len = 6'd31;
      "MU": len = 6'd30; "NL": len = 6'd18; "NO": len = 6'd15; "OM": len = 6'd23;
      "PK": len = 6'd24; "PL": len = 6'd28; "PS": len = 6'd29; "PT": len = 6'd25;
      "QA": len = 6'd29; "RO": len = 6'd24; "RS": len = 6'd22; "RU": len = 6'd33;
      "SA": len = 6'd24; "SC": len = 6'd31; "SD": len = 6'd18; "SE": len = 6'd24;
      "SI": len = 6'd19; "SK": len = 6'd24; "SM": len = 6'd27; "SO": len = 6'd23;
      "ST": len = 6'd25; "SV": len = 6'd28; "TL": len = 6'd23; "TN": len = 6'd24;
      "TR": len = 6'd26; "UA": len = 6'd29; "VA": len = 6'd22; "VG": len = 6'd24;
      "YE": len = 6'd30;
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

// File: src/icv_char_if.sv
`timescale 1ns / 1ps

interface icv_char_if;
  import icv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source(output valid, char_code, last_char, input ready);
  modport sink(input valid, char_code, last_char, output ready);
endinterface

// File: src/icv_result_if.sv
`timescale 1ns / 1ps

interface icv_result_if;
  logic valid;
  logic ready;
  logic iban_valid;

  modport source(output valid, iban_valid, input ready);
  modport sink(input valid, iban_valid, output ready);
endinterface

// File: src/iban_checksum_validator.sv
`timescale 1ns / 1ps

// IBAN checksum validator, one character per transfer.
// chars:  one ASCII byte per transfer, last_char set on the final character.
// result: one transfer per IBAN, iban_valid = 1 when every check passed.
// Throughput: one character per cycle while result is drained. The per-character
//   mod-97 fold and flag update sit between the running state and a snapshot
//   register; the length lookup and final remainder sit between the snapshot
//   and the result register.
// Path: the last character loads the snapshot, then the result register.
// Stall: the result register and the snapshot register each hold one IBAN, so
//   characters keep flowing while a result waits; chars.ready drops only when
//   both are full and result.ready is low.
// Reset (rst, synchronous): running state returns to an empty IBAN, both
//   output stages go empty. After each last character the running state
//   clears the same way, so the next transfer starts a new IBAN.
// The prefix (country code, check digits) is folded as its own remainder
//   and joined at the end as rem * 10^6 + prefix, which is exact whenever the
//   prefix passed the letter and digit checks.
module iban_checksum_validator (
  input logic         clk,
  input logic         rst,
  icv_char_if.sink    chars,
  icv_result_if.source result
);
  import icv_pkg::*;

  // running state of the IBAN being received
  logic [3:0][CHAR_W-1:0] prefix_store, prefix_next;
  logic [REM_W-1:0]       prefix_rem, prefix_rem_next;
  logic [CNT_W-1:0]       char_count, char_count_next;
  logic [REM_W-1:0]       mod_remainder, mod_remainder_next;
  logic [REM_W-1:0]       national_remainder, national_remainder_next;
  logic [REM_W-1:0]       national_tail, national_tail_next;
  logic                   chars_ok, chars_ok_next;
  logic                   national_digits_ok, national_digits_ok_next;

  // snapshot of a finished IBAN
  logic                   snap_valid;
  logic [CNT_W-1:0]       snap_total;
  logic [CHAR_W-1:0]      snap_c0, snap_c1;
  logic                   snap_check_dig;
  logic                   snap_chars_ok;
  logic [REM_W-1:0]       snap_rem;
  logic [REM_W-1:0]       snap_prefix_rem;
  logic                   snap_nat_ok;
  logic [REM_W-1:0]       snap_nat_rem;
  logic [REM_W-1:0]       snap_nat_tail;

  // result register
  logic                   res_valid;
  logic                   res_bit;

  logic                   in_xfer, res_load;
  logic [CHAR_W-1:0]      c_up;
  logic [CNT_W-1:0]       bban_idx;
  logic                   is_prefix;

  assign res_load    = snap_valid && (!res_valid || result.ready);
  assign chars.ready = !snap_valid || res_load;
  assign in_xfer     = chars.valid && chars.ready;

  assign is_prefix = char_count < CNT_W'(PREFIX_LEN);
  assign bban_idx  = char_count - CNT_W'(PREFIX_LEN);
  // lowercase BBAN letters fold as uppercase
  assign c_up = is_lower(chars.char_code) ? chars.char_code - CASE_OFFSET
                                          : chars.char_code;

  // per-character update
  always_comb begin
    prefix_next             = prefix_store;
    prefix_rem_next         = prefix_rem;
    mod_remainder_next      = mod_remainder;
    national_remainder_next = national_remainder;
    national_tail_next      = national_tail;
    chars_ok_next           = chars_ok;
    national_digits_ok_next = national_digits_ok;
    char_count_next = (char_count == CNT_MAX) ? char_count : char_count + 1'b1;
    if (is_prefix) begin
      prefix_next[char_count[1:0]] = chars.char_code;
      prefix_rem_next = fold_char(prefix_rem, chars.char_code);
    end else begin
      if (is_upper(c_up) || is_digit(c_up)) begin
        mod_remainder_next = fold_char(mod_remainder, c_up);
      end else begin
        chars_ok_next = 1'b0;
      end
      if (is_digit(c_up)) begin
        if (bban_idx < NAT_HEAD) begin
          national_remainder_next = fold_char(national_remainder, c_up);
        end else if (bban_idx < NAT_LEN) begin
          national_tail_next = REM_W'(11'(national_tail) * 11'd10 + 11'(c_up[3:0]));
        end
      end else begin
        national_digits_ok_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_xfer && chars.last_char)) begin
      prefix_store       <= '0;
      prefix_rem         <= '0;
      char_count         <= '0;
      mod_remainder      <= '0;
      national_remainder <= '0;
      national_tail      <= '0;
      chars_ok           <= 1'b1;
      national_digits_ok <= 1'b1;
    end else if (in_xfer) begin
      prefix_store       <= prefix_next;
      prefix_rem         <= prefix_rem_next;
      char_count         <= char_count_next;
      mod_remainder      <= mod_remainder_next;
      national_remainder <= national_remainder_next;
      national_tail      <= national_tail_next;
      chars_ok           <= chars_ok_next;
      national_digits_ok <= national_digits_ok_next;
    end
  end

  // snapshot stage
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= (in_xfer && chars.last_char) || (snap_valid && !res_load);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && chars.last_char) begin
      snap_total      <= char_count_next;
      snap_c0         <= prefix_next[0];
      snap_c1         <= prefix_next[1];
      snap_check_dig  <= is_digit(prefix_next[2]) && is_digit(prefix_next[3]);
      snap_chars_ok   <= chars_ok_next;
      snap_rem        <= mod_remainder_next;
      snap_prefix_rem <= prefix_rem_next;
      snap_nat_ok     <= national_digits_ok_next;
      snap_nat_rem    <= national_remainder_next;
      snap_nat_tail   <= national_tail_next;
    end
  end

  // final checks
  logic [CNT_W-1:0] exp_len;
  logic [REM_W-1:0] final_rem;
  logic [REM_W-1:0] nat_rem100;
  logic             base_ok, is_si, si_ok, verdict;

  always_comb begin
    exp_len    = rom_length(snap_c0, snap_c1);
    final_rem  = mod97(12'(snap_rem) * PREFIX_MUL + 12'(snap_prefix_rem));
    nat_rem100 = mod97(12'(snap_nat_rem) * LETTER_MUL);
    base_ok    = (snap_total > CNT_W'(PREFIX_LEN)) && (exp_len != '0)
                 && (snap_total == exp_len) && snap_check_dig && snap_chars_ok;
    is_si      = (snap_c0 == CH_S) && (snap_c1 == CH_I);
    si_ok      = snap_nat_ok && (snap_total == NAT_LEN + CNT_W'(PREFIX_LEN))
                 && ((SI_BASE - nat_rem100) == snap_nat_tail);
    verdict    = base_ok && (final_rem == REM_W'(1)) && (!is_si || si_ok);
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_bit <= verdict;
    end
  end

  assign result.valid      = res_valid;
  assign result.iban_valid = res_bit;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_last_fills_snap, clk, rst, in_xfer && chars.last_char, snap_valid, "last character did not reach the snapshot")
  `ASSERT_NEXT(a_last_clears_state, clk, rst, in_xfer && chars.last_char, char_count == '0 && chars_ok && national_digits_ok, "state not cleared after last character")
  `ASSERT_NEXT(a_count_step, clk, rst, in_xfer && !chars.last_char && char_count != CNT_MAX, char_count == $past(char_count) + 1'b1, "character count did not advance")
  `ASSERT_NEXT(a_snap_held, clk, rst, snap_valid && !res_load, snap_valid && $stable(snap_rem), "pending snapshot lost")

endmodule

// File: test/tb_iban_checksum_validator.sv
`timescale 1ns / 1ps

module tb_iban_checksum_validator;
  import icv_pkg::*;

  // mod-97 check constants
  localparam int MOD_PRIME     = 97;
  localparam int SI_CHECK_BASE = 98;
  localparam int SI_HEAD       = 13;
  localparam int SI_BBAN       = 15;
  localparam int MIN_LEN       = 4;

  // country code / length table, four characters per entry: code, two-digit length
  localparam int ENTRIES     = 85;
  localparam int TABLE_CHARS = 4 * ENTRIES;
  localparam logic [8*TABLE_CHARS-1:0] COUNTRIES = {
    "AD24AE23AL28AT20AZ28BA20BE16BG22BH22BI27BR29BY28CH21CR22CY28CZ24DE22DJ27",
    "DK18DO28EE20EG29ES24FI18FO18FR27GB22GE22GI23GL18GR27GT28HR21HU28IE22IL23",
    "IQ23IS26IT27JO30KM27KW30KZ20LB28LC32LI21LT20LU20LV21LY25MC27MD24ME22MK19",
    "MR27MT31MU30NL18NO15OM23PK24PL28PS29PT25QA29RO24RS22RU33SA24SC31SD18SE24",
    "SI19SK24SM27SO23ST25SV28TL23TN24TR26UA29VA22VG24YE30"
  };
  localparam int NO_ENTRY = 58;
  localparam int SI_ENTRY = 72;

  localparam int RANDOM_CHARS = 1200;
  localparam int STEADY_FROM  = 400;   // window with no random idling on either side
  localparam int STEADY_TO    = 700;
  localparam int IDLE_PCT     = 25;

  // ways a well-formed IBAN gets broken
  typedef enum int {
    FLAW_BYTE,
    FLAW_LOWER_COUNTRY,
    FLAW_LOWER_CHECK,
    FLAW_DROP,
    FLAW_EXTRA,
    FLAW_SWAP,
    FLAW_SI_NATIONAL,
    FLAW_SI_LETTER
  } flaw_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              drain_first;  // hold until every verdict is back
  } char_item_t;

  logic clk = 1'b0;
  logic rst;

  icv_char_if   chars_bus ();
  icv_result_if result_bus ();

  iban_checksum_validator u_top (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_bus),
    .result (result_bus)
  );

  always #5 clk = ~clk;

  char_item_t        pending_chars[$];  // driver feed
  logic [CHAR_W-1:0] text[$];           // IBAN string under construction
  bit                verdicts[$];       // predicted iban_valid, oldest first
  int                chars_done = 0;
  int                errors = 0;

  // running state of the predicted validator
  logic [31:0] prefix_chars;
  int          seen_count;
  int          bban_rem;
  int          si_head_rem;
  int          si_tail;
  bit          bban_alnum;
  bit          bban_decimal;

  function automatic bit is_dec(logic [CHAR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_cap(logic [CHAR_W-1:0] c);
    return c >= CH_UP_A && c <= CH_UP_Z;
  endfunction

  function automatic bit is_small(logic [CHAR_W-1:0] c);
    return c >= CH_LO_A && c <= CH_LO_Z;
  endfunction

  // letters fold as two decimal digits (10..35), digits as one
  function automatic int fold_into_rem(int r, logic [CHAR_W-1:0] c);
    int v;
    if (is_cap(c)) begin
      v = int'(c) - int'(CH_UP_A) + 10;
      r = (r * 10 + v / 10) % MOD_PRIME;
      r = (r * 10 + v % 10) % MOD_PRIME;
    end else if (is_dec(c)) begin
      r = (r * 10 + int'(c) - int'(CH_ZERO)) % MOD_PRIME;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] table_byte(int k);
    return COUNTRIES[8*(TABLE_CHARS-1-k) +: 8];
  endfunction

  function automatic int country_length(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b);
    for (int i = 0; i < ENTRIES; i++) begin
      if (table_byte(4*i) == a && table_byte(4*i+1) == b) begin
        return (int'(table_byte(4*i+2)) - int'(CH_ZERO)) * 10
               + int'(table_byte(4*i+3)) - int'(CH_ZERO);
      end
    end
    return 0;
  endfunction

  function automatic bit steady_phase();
    return chars_done >= STEADY_FROM && chars_done < STEADY_TO;
  endfunction

  task automatic clear_model();
    prefix_chars = '0;
    seen_count   = 0;
    bban_rem     = 0;
    si_head_rem  = 0;
    si_tail      = 0;
    bban_alnum   = 1'b1;
    bban_decimal = 1'b1;
  endtask

  // Advance the predicted state by one accepted character; on the last one
  // queue the verdict and start a fresh IBAN.
  task automatic model_char(logic [CHAR_W-1:0] code, logic last);
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] c0, c1, c2, c3;
    int                pos, want_len, r, nr;
    bit                ok;
    c   = code;
    pos = seen_count;
    if (pos < MIN_LEN) begin
      prefix_chars[8*pos +: 8] = c;
    end else begin
      if (is_small(c)) begin
        c = c - CASE_OFFSET;
      end
      if (is_cap(c) || is_dec(c)) begin
        bban_rem = fold_into_rem(bban_rem, c);
      end else begin
        bban_alnum = 1'b0;
      end
      if (is_dec(c)) begin
        if (pos - MIN_LEN < SI_HEAD) begin
          si_head_rem = fold_into_rem(si_head_rem, c);
        end else if (pos - MIN_LEN < SI_BBAN) begin
          si_tail = si_tail * 10 + int'(c) - int'(CH_ZERO);
        end
      end else begin
        bban_decimal = 1'b0;
      end
    end
    if (seen_count < int'(CNT_MAX)) begin
      seen_count++;
    end
    if (last) begin
      c0       = prefix_chars[7:0];
      c1       = prefix_chars[15:8];
      c2       = prefix_chars[23:16];
      c3       = prefix_chars[31:24];
      want_len = country_length(c0, c1);
      ok = seen_count > MIN_LEN && want_len != 0 && seen_count == want_len
           && is_dec(c2) && is_dec(c3) && bban_alnum;
      if (ok) begin
        r = bban_rem;
        r = fold_into_rem(r, c0);
        r = fold_into_rem(r, c1);
        r = fold_into_rem(r, c2);
        r = fold_into_rem(r, c3);
        ok = (r == 1);
      end
      // SI: national check over a 15-digit BBAN
      if (ok && c0 == CH_S && c1 == CH_I) begin
        nr = (si_head_rem * 100) % MOD_PRIME;
        ok = bban_decimal && seen_count - MIN_LEN == SI_BBAN
             && SI_CHECK_BASE - nr == si_tail;
      end
      verdicts.insert(verdicts.size(), ok);
      clear_model();
    end
  endtask

  function automatic logic [CHAR_W-1:0] rand_alnum();
    int v;
    v = $urandom_range(0, 35);
    return (v < 10) ? CHAR_W'(int'(CH_ZERO) + v) : CHAR_W'(int'(CH_UP_A) + v - 10);
  endfunction

  // Overwrite the check digits so the whole string folds to 1.
  task automatic seal_check_digits();
    int r, chk;
    r = 0;
    for (int i = MIN_LEN; i < text.size(); i++) begin
      r = fold_into_rem(r, text[i]);
    end
    r = fold_into_rem(r, text[0]);
    r = fold_into_rem(r, text[1]);
    r = fold_into_rem(r, CH_ZERO);
    r = fold_into_rem(r, CH_ZERO);
    chk = SI_CHECK_BASE - r;
    text[2] = CHAR_W'(int'(CH_ZERO) + chk / 10);
    text[3] = CHAR_W'(int'(CH_ZERO) + chk % 10);
  endtask

  // Correct IBAN for one table entry; SI gets a proper national check
  // unless bad_national is set.
  task automatic make_valid(int entry, bit bad_national);
    logic [CHAR_W-1:0] a, b;
    int                len, head, tail, d;
    a   = table_byte(4*entry);
    b   = table_byte(4*entry+1);
    len = country_length(a, b);
    text.delete();
    text.insert(text.size(), a);
    text.insert(text.size(), b);
    text.insert(text.size(), CH_ZERO);
    text.insert(text.size(), CH_ZERO);
    if (a == CH_S && b == CH_I) begin
      head = 0;
      repeat (SI_HEAD) begin
        d = $urandom_range(0, 9);
        text.insert(text.size(), CHAR_W'(int'(CH_ZERO) + d));
        head = (head * 10 + d) % MOD_PRIME;
      end
      tail = SI_CHECK_BASE - (head * 100) % MOD_PRIME;
      if (bad_national) begin
        tail = (tail + $urandom_range(1, 99)) % 100;
      end
      text.insert(text.size(), CHAR_W'(int'(CH_ZERO) + tail / 10));
      text.insert(text.size(), CHAR_W'(int'(CH_ZERO) + tail % 10));
    end else begin
      while (text.size() < len) begin
        text.insert(text.size(), rand_alnum());
      end
    end
    seal_check_digits();
  endtask

  // lowercase BBAN letters must still pass
  task automatic scramble_case();
    for (int i = MIN_LEN; i < text.size(); i++) begin
      if (is_cap(text[i]) && $urandom_range(0, 2) == 0) begin
        text[i] = text[i] + CASE_OFFSET;
      end
    end
  endtask

  task automatic push_text(bit drain);
    char_item_t item;
    for (int i = 0; i < text.size(); i++) begin
      item.code        = text[i];
      item.last        = (i == text.size() - 1);
      item.drain_first = drain && (i == 0);
      pending_chars.insert(pending_chars.size(), item);
    end
  endtask

  function automatic int pick_country();
    return ($urandom_range(0, 5) == 0) ? SI_ENTRY : $urandom_range(0, ENTRIES - 1);
  endfunction

  task automatic make_flawed();
    flaw_t             flaw;
    int                p;
    logic [CHAR_W-1:0] t;
    flaw = flaw_t'($urandom_range(0, 7));
    if (flaw == FLAW_SI_NATIONAL) begin
      make_valid(SI_ENTRY, 1'b1);
    end else if (flaw == FLAW_SI_LETTER) begin
      // IBAN checksum still right, but the BBAN is no longer all digits
      make_valid(SI_ENTRY, 1'b0);
      text[$urandom_range(MIN_LEN, text.size() - 1)] =
        CHAR_W'(int'(CH_UP_A) + $urandom_range(0, 25));
      seal_check_digits();
    end else begin
      make_valid(pick_country(), 1'b0);
    end
    scramble_case();
    case (flaw)
      FLAW_BYTE: begin
        text[$urandom_range(0, text.size() - 1)] = CHAR_W'($urandom_range(0, 255));
      end
      FLAW_LOWER_COUNTRY: begin
        p = $urandom_range(0, 1);
        text[p] = text[p] + CASE_OFFSET;
      end
      FLAW_LOWER_CHECK: begin
        text[$urandom_range(2, 3)] = CHAR_W'(int'(CH_LO_A) + $urandom_range(0, 25));
      end
      FLAW_DROP: begin
        void'(text.pop_back());
      end
      FLAW_EXTRA: begin
        text.insert(text.size(), rand_alnum());
      end
      FLAW_SWAP: begin
        p = $urandom_range(0, text.size() - 2);
        t = text[p];
        text[p] = text[p+1];
        text[p+1] = t;
      end
      default: begin
      end
    endcase
  endtask

  // Driver: a character is transferred on an edge with valid and ready high;
  // the predictor sees it right there, then the next one is offered.
  always @(posedge clk) begin
    char_item_t item;
    bit         hold;
    if (rst) begin
      chars_bus.valid <= 1'b0;
    end else begin
      if (chars_bus.valid && chars_bus.ready) begin
        model_char(chars_bus.char_code, chars_bus.last_char);
        chars_done++;
      end
      if (!chars_bus.valid || chars_bus.ready) begin
        hold = (pending_chars.size() == 0)
               || (!steady_phase() && $urandom_range(0, 99) < IDLE_PCT);
        // pause until the block has nothing in flight
        if (!hold && pending_chars[0].drain_first && verdicts.size() != 0) begin
          hold = 1'b1;
        end
        if (hold) begin
          chars_bus.valid <= 1'b0;
        end else begin
          item = pending_chars.pop_front();
          chars_bus.valid     <= 1'b1;
          chars_bus.char_code <= item.code;
          chars_bus.last_char <= item.last;
        end
      end
    end
  end

  // Monitor: each result transfer is matched against the oldest verdict.
  always @(posedge clk) begin
    bit want;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer, expected none, got iban_valid=%0b",
                   $time, result_bus.iban_valid);
        end else begin
          want = verdicts.pop_front();
          if (result_bus.iban_valid !== want) begin
            errors++;
            $display("%0t: iban_valid mismatch, expected %0b, got %0b",
                     $time, want, result_bus.iban_valid);
          end
        end
      end
      result_bus.ready <= steady_phase() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("[iban_checksum_validator] ERROR");
    $finish;
  end

  initial begin
    int kind, strings;
    chars_bus.valid     = 1'b0;
    chars_bus.char_code = '0;
    chars_bus.last_char = 1'b0;
    result_bus.ready    = 1'b0;
    rst                 = 1'b1;
    clear_model();

    // Directed: a lone NUL as a whole string (too short), a four-character
    // string with a high byte, then a well-formed NO IBAN with randomly lowercased BBAN letters.
    text = '{8'h00};
    push_text(1'b0);
    text = '{8'hff, "a", "9", "Z"};
    push_text(1'b0);
    make_valid(NO_ENTRY, 1'b0);
    scramble_case();
    push_text(1'b0);

    // Random: mostly well-formed IBANs, mixed with broken ones, short strings and
    // overlong ones that can push the length counter into saturation.
    strings = 0;
    while (pending_chars.size() < RANDOM_CHARS + 20) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        make_valid(pick_country(), 1'b0);
        scramble_case();
      end else if (kind < 80) begin
        make_flawed();
      end else if (kind < 90) begin
        text.delete();
        repeat ($urandom_range(1, MIN_LEN)) begin
          text.insert(text.size(),
                      ($urandom_range(0, 1) == 0) ? CHAR_W'($urandom_range(0, 255))
                                                  : rand_alnum());
        end
      end else if (kind < 95) begin
        make_valid(pick_country(), 1'b0);
        while (text.size() < $urandom_range(60, 70)) begin
          text.insert(text.size(), rand_alnum());
        end
      end else begin
        text.delete();
        repeat ($urandom_range(5, 70)) begin
          text.insert(text.size(), CHAR_W'($urandom_range(0, 255)));
        end
      end
      push_text(strings % 10 == 0);
      strings++;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do begin
      @(negedge clk);
    end while (pending_chars.size() != 0 || chars_bus.valid || verdicts.size() != 0);
    // let any stray result surface
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("[iban_checksum_validator] OK");
    end else begin
      $display("[iban_checksum_validator] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/icv_pkg.sv
src/icv_char_if.sv
src/icv_result_if.sv
src/iban_checksum_validator.sv
test/tb_iban_checksum_validator.sv
